// ===== design/itda_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the signed
// integer to decimal ASCII converter. No dependencies.
package itda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Control for the row of BCD digit cells.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } t_cell_ctl;

    // Number of decimal digits in 2^(w-1), the largest magnitude of a
    // w-bit two's complement value.
    function automatic int num_digits(input int w);
        logic [64:0] v;
        int          n;
        v = 65'd1 << (w - 1);
        n = 0;
        for (int i = 0; i < 21; i++) begin
            if (v != 65'd0) begin
                n = n + 1;
                v = v / 65'd10;
            end
        end
        return n;
    endfunction

endpackage

// ===== design/itda_cell.sv =====
// One BCD digit cell of the conversion row: add-3 adjust and shift during
// conversion, digit hand-over toward the top during output. Uses itda_pkg.
module itda_cell (
    input  logic                i_clk,
    input  itda_pkg::t_cell_ctl i_ctl,
    input  logic                i_bit_in,
    input  logic [3:0]          i_digit_in,
    output logic                o_bit_out,
    output logic [3:0]          o_digit
);
    import itda_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_adj;

    // A digit of five or more overflows past nine when doubled, so it is
    // corrected by three before the shift.
    assign n_adj     = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit_out = n_adj[3];
    assign o_digit   = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctl.dabble) begin
            r_digit <= {n_adj[2:0], i_bit_in};
        end else if (i_ctl.shift) begin
            r_digit <= i_digit_in;
        end
    end

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on itda_pkg and itda_cell.
//
// Usage: a request is taken on the rising edge where start is high and busy
// is low; i_value is sampled then. The block answers with the decimal text
// of the value, in ASCII on o_character, each character marked by a one-cycle
// o_valid strobe, most significant first; after the first digit one digit comes
// per cycle. A negative value gets a leading '-'. Zero gives a single '0'.
// o_last marks the final character of the text.
//
// Timing: the magnitude is converted by a row of BCD digit cells with the
// shift-and-add-3 method, one bit per cycle. Then the sign is strobed if
// present, and the digit row shifts toward the top one digit per cycle:
// leading zeros are dropped silently and the rest are emitted; there are 10
// digit cells at 32 bits. busy is high through conversion, sign and output.
// The last character is strobed in the first cycle with busy low, and the
// next request can be taken at the edge that ends it.
//
// Reset (synchronous, active low) returns the block to idle; any text in
// progress is dropped. The receiver cannot stall: every strobed character
// is taken in the cycle it is shown.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   busy,
    output logic                   o_valid,
    output logic [7:0]             o_character,
    output logic                   o_last
);
    import itda_pkg::*;

    localparam int NUM_DIG = num_digits(VALUE_WIDTH);
    localparam int STEP_W  = $clog2(VALUE_WIDTH);
    localparam int REM_W   = $clog2(NUM_DIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic                   r_neg;
    logic [STEP_W-1:0]      r_step;
    logic [REM_W-1:0]       r_rem;
    logic                   r_seen;
    logic                   r_valid;
    logic [7:0]             r_character;
    logic                   r_last;

    t_cell_ctl  w_ctl;
    logic       w_bit   [NUM_DIG];
    logic [3:0] w_digit [NUM_DIG];
    logic [3:0] w_top;
    logic       w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign w_top    = w_digit[NUM_DIG-1];

    // The cells clear on a new request, take one magnitude bit per cycle
    // during conversion and hand their digits upward during output.
    always_comb begin
        w_ctl.clear  = w_accept;
        w_ctl.dabble = (r_state == S_CONV);
        w_ctl.shift  = (r_state == S_EMIT);
    end

    for (genvar g = 0; g < NUM_DIG; g++) begin : g_cell
        logic       w_bit_in;
        logic [3:0] w_digit_in;
        if (g == 0) begin : g_first
            assign w_bit_in   = r_mag[VALUE_WIDTH-1];
            assign w_digit_in = 4'd0;
        end else begin : g_rest
            assign w_bit_in   = w_bit[g-1];
            assign w_digit_in = w_digit[g-1];
        end
        itda_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_bit_in   (w_bit_in),
            .i_digit_in (w_digit_in),
            .o_bit_out  (w_bit[g]),
            .o_digit    (w_digit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // The magnitude is taken as an unsigned number, so the
                        // most negative value negates to itself and converts
                        // correctly.
                        r_neg   <= i_value[VALUE_WIDTH-1];
                        r_mag   <= i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
                        r_step  <= STEP_W'(VALUE_WIDTH - 1);
                        r_seen  <= 1'b0;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
                    if (r_step == '0) begin
                        r_rem   <= REM_W'(NUM_DIG);
                        r_state <= r_neg ? S_SIGN : S_EMIT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_SIGN: begin
                    r_valid     <= 1'b1;
                    r_character <= CHAR_MINUS;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    // Leading zeros pass out of the top unseen; once a digit
                    // has been shown, every later one is shown too. The lowest
                    // digit is always shown so that zero gives '0'.
                    if (w_top != 4'd0 || r_rem == REM_W'(1) || r_seen) begin
                        r_seen      <= 1'b1;
                        r_valid     <= 1'b1;
                        r_character <= CHAR_ZERO + {4'd0, w_top};
                        r_last      <= (r_rem == REM_W'(1));
                    end
                    if (r_rem == REM_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                    r_rem <= r_rem - 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_character;
    assign o_last      = r_last;

endmodule

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// Testbench for signed_int_to_decimal_ascii. It sends signed values through
// the start/busy request handshake and checks every strobed ASCII character
// against a decimal formatter or typed text in the bench. Depends on itda_pkg and the RTL.
module tb_signed_int_to_decimal_ascii;
    import itda_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int DRAIN_CYCLES = 60;    // a little more than one full request
    localparam int STALL_LIMIT  = 2000;  // cycles with no request taken and no character
    localparam int PHASE_ITEMS  = 100;
    localparam int REPORT_MAX   = 10;

    localparam logic [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] MOST_POS = ~MOST_NEG;

    // One character of expected text, in the order the block must strobe it.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_char;

    // A directed request. An empty text means the formatter supplies the
    // expected characters; otherwise the text is the expected output.
    typedef struct {
        logic [VW-1:0] value;
        string         text;
    } t_directed_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic [VW-1:0] i_value;
    logic          busy;
    logic          o_valid;
    logic [7:0]    o_character;
    logic          o_last;

    t_text_char pending_chars[$];
    int         mismatch_count;
    int         chars_checked;
    int         numbers_sent;
    int         negatives_sent;
    int         idle_pct;
    int         quiet_cycles;

    // The directed part: zero, single digits, several power-of-ten boundaries that
    // change the text length, both extremes of the range, the most negative
    // value in particular, and alternating bit patterns so that every input
    // bit is seen high and low early on.
    t_directed_row directed_rows [20] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{-32'sd1,        "-1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{-32'sd10,       "-10"},
        '{32'd100,        "100"},
        '{-32'sd100000,   "-100000"},
        '{32'd999999999,  "999999999"},
        '{-32'sd999999999, "-999999999"},
        '{32'd1000000000, "1000000000"},
        '{32'h7FFF_FFFF,  "2147483647"},
        '{32'h8000_0000,  "-2147483648"},
        '{32'h8000_0001,  "-2147483647"},
        '{32'h5555_5555,  ""},
        '{32'hAAAA_AAAA,  ""},
        '{32'h0000_FFFF,  ""},
        '{32'hFFFF_0000,  ""},
        '{32'h1234_5678,  ""},
        '{32'hEDCB_A988,  ""}
    };

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // Period of 8: low for 4, high for 4.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Formats a two's complement value as decimal text and appends it to the
    // expected characters. The magnitude is taken modulo 2^VW, which gives
    // 2^(VW-1) for the most negative value instead of overflowing.
    function automatic void queue_decimal_text(input logic [VW-1:0] value);
        logic [VW-1:0] magnitude;
        logic [7:0]    text_chars[$];
        magnitude = value[VW-1] ? (~value + 1'b1) : value;
        do begin
            text_chars.push_front(CHAR_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (value[VW-1]) begin
            text_chars.push_front(CHAR_MINUS);
        end
        foreach (text_chars[k]) begin
            pending_chars.push_back('{text_chars[k], k == text_chars.size() - 1});
        end
    endfunction

    // Appends text that was written out by hand in the directed table.
    function automatic void queue_typed_text(input string text);
        for (int k = 0; k < text.len(); k++) begin
            pending_chars.push_back('{text[k], k == text.len() - 1});
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endfunction

    // Presents one request. It is entered and left at a falling edge. Before
    // the request is raised, the sender may sit idle for random cycles, and
    // in those cycles i_value carries noise that the block must not sample.
    // Once raised, start stays high until a rising edge sees busy low; the
    // expected text is queued right at that edge.
    task automatic send_request(input logic [VW-1:0] value, input string text);
        while ($urandom_range(0, 99) < idle_pct) begin
            start   <= 1'b0;
            i_value <= $urandom;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (text.len() == 0) begin
            queue_decimal_text(value);
        end else begin
            queue_typed_text(text);
        end
        numbers_sent++;
        negatives_sent += value[VW-1];
        @(negedge i_clk);
    endtask

    // Random requests with a given sender idle rate. The mix leans toward
    // values whose text length is at a boundary: small numbers of both signs,
    // powers of ten and their neighbors, and values near both extremes, with
    // a third of the requests spread over the whole range.
    task automatic run_random_phase(input int sender_idle_pct);
        logic [VW-1:0] value;
        logic [VW-1:0] power;
        idle_pct = sender_idle_pct;
        repeat (PHASE_ITEMS) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    value = $urandom;
                end
                2: begin
                    value = VW'($urandom_range(0, 999));
                end
                3: begin
                    value = '0 - VW'($urandom_range(1, 999));
                end
                4: begin
                    power = 1;
                    repeat ($urandom_range(0, 9)) begin
                        power = power * 10;
                    end
                    value = power + VW'($urandom_range(0, 2)) - 1'b1;
                    if ($urandom_range(0, 1) == 1) begin
                        value = '0 - value;
                    end
                end
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        value = MOST_NEG + VW'($urandom_range(0, 3));
                    end else begin
                        value = MOST_POS - VW'($urandom_range(0, 3));
                    end
                end
            endcase
            send_request(value, "");
        end
    endtask

    // Every strobed character is matched against the oldest expected one.
    // Outputs are read in the active region of the rising edge, so they still
    // hold the values of the cycle that this edge ends.
    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && o_valid) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("character 0x%02h last %0b with nothing expected",
                                          o_character, o_last));
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_character !== want.character) begin
                    report_mismatch($sformatf("character: expected 0x%02h, got 0x%02h",
                                              want.character, o_character));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last on 0x%02h: expected %0b, got %0b",
                                              want.character, want.last, o_last));
                end
            end
        end
    end

    // A correct block never goes this long without taking a request or
    // strobing a character, even at the highest sender idle rate.
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d characters outstanding.",
                     quiet_cycles, pending_chars.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        start          = 1'b0;
        i_value        = '0;
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        chars_checked  = 0;
        numbers_sent   = 0;
        negatives_sent = 0;
        idle_pct       = 0;
        quiet_cycles   = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests, then random ones: first with a sender idle chance of
        // 30% before each request, then 67%, then back to back.
        idle_pct = 30;
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].value, directed_rows[r].text);
        end
        run_random_phase(30);
        run_random_phase(67);
        run_random_phase(0);
        start <= 1'b0;

        // Let the last text drain, then watch a while longer for stray strobes.
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers (%0d negative), %0d characters checked.",
                 numbers_sent, negatives_sent, chars_checked);
        $display("Mismatches: %0d (sender idle rates 30%%, 67%% and none).", mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
